// ===== rtl/core/sdf_pkg.sv =====
// Package for the spring-damper force pair: widths, types, register indexes, helpers.
`default_nettype none

package sdf_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRACTION_BITS = 16;
   localparam int UNIT_BITS     = 30;
   localparam int CFG_BITS      = WORD_BITS - 1;
   localparam int MAG_BITS      = WORD_BITS + 1;
   localparam int SQ_BITS       = 2 * MAG_BITS;
   localparam int LEN_BITS      = MAG_BITS + 1;
   localparam int ROOT_STEPS    = LEN_BITS;
   localparam int RAD_BITS      = 2 * ROOT_STEPS;
   localparam int REM_BITS      = LEN_BITS + 2;
   localparam int QUO_BITS      = UNIT_BITS + 1;
   localparam int DREM_BITS     = LEN_BITS + 1;
   localparam int PROD_BITS     = 2 * WORD_BITS;
   localparam int ACC_BITS      = PROD_BITS + 2;
   localparam int WIDE_BITS     = 72;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_BITS-1:0] REST_RESET  = CFG_BITS'(65536);
   localparam logic [CFG_BITS-1:0] STIFF_RESET = CFG_BITS'(65536);
   localparam logic [CFG_BITS-1:0] DAMP_RESET  = CFG_BITS'(0);

   typedef enum logic [1:0] {
      CSR_REST  = 2'd0,
      CSR_STIFF = 2'd1,
      CSR_DAMP  = 2'd2
   } csr_index_type;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   typedef struct packed {
      word_type first_pos_x;
      word_type first_pos_y;
      word_type first_pos_z;
      word_type second_pos_x;
      word_type second_pos_y;
      word_type second_pos_z;
      word_type first_vel_x;
      word_type first_vel_y;
      word_type first_vel_z;
      word_type second_vel_x;
      word_type second_vel_y;
      word_type second_vel_z;
   } req_type;

   typedef struct packed {
      word_type first_force_x;
      word_type first_force_y;
      word_type first_force_z;
      word_type second_force_x;
      word_type second_force_y;
      word_type second_force_z;
   } rsp_type;

   // classified request: coincident flag, |d| with its sign, both velocities
   typedef struct packed {
      logic                         zero;
      logic [2:0]                   neg;
      logic [2:0][MAG_BITS-1:0]     mag;
      logic [2:0][WORD_BITS-1:0]    va;
      logic [2:0][WORD_BITS-1:0]    vb;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   function automatic word_type sat_word(input wide_type x);
      wide_type hi;
      wide_type lo;
      hi = {{(WIDE_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
      lo = ~hi;
      if (x > hi) begin
         return word_type'(hi);
      end else if (x < lo) begin
         return word_type'(lo);
      end
      return word_type'(x);
   endfunction

   // shift toward zero
   function automatic wide_type trunc_shift(input wide_type x, input int unsigned sh);
      wide_type mag;
      mag = x[WIDE_BITS-1] ? -x : x;
      mag = mag >> sh;
      return x[WIDE_BITS-1] ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spring_damper_force_pair.sv =====
// Top level of the spring-damper force pair with its register port.
// Throughput: one request per cycle; the root and divider pipelines retire one bit a stage.
// busy only rises if the two-entry queue fills, which the free-running back end prevents.
// Synchronous active-high reset empties the pipeline and loads register defaults.
`default_nettype none

module spring_damper_force_pair import sdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   logic [CFG_BITS-1:0] rest_ff, stiff_ff, damp_ff;
   slot_type            q_slot;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= REST_RESET;
         stiff_ff <= STIFF_RESET;
         damp_ff  <= DAMP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REST:  rest_ff  <= csr_data[CFG_BITS-1:0];
            CSR_STIFF: stiff_ff <= csr_data[CFG_BITS-1:0];
            CSR_DAMP:  damp_ff  <= csr_data[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   sdf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_out    (q_slot)
   );

   sdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_in       (q_slot),
      .rest       (rest_ff),
      .stiff      (stiff_ff),
      .damp       (damp_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/sdf_front.sv =====
// Front end: takes requests, forms and classifies the separation, buffers in a short queue.
`default_nettype none

module sdf_front import sdf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output slot_type q_out
);

   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   item_type             slot_ff [QUEUE_DEPTH];
   item_type             item_in;
   logic                 push, pop;
   word_type             fp [3];
   word_type             sp [3];
   logic signed [MAG_BITS-1:0] d [3];

   always_comb begin
      fp[0] = req_data.first_pos_x;
      fp[1] = req_data.first_pos_y;
      fp[2] = req_data.first_pos_z;
      sp[0] = req_data.second_pos_x;
      sp[1] = req_data.second_pos_y;
      sp[2] = req_data.second_pos_z;
      item_in.va[0] = req_data.first_vel_x;
      item_in.va[1] = req_data.first_vel_y;
      item_in.va[2] = req_data.first_vel_z;
      item_in.vb[0] = req_data.second_vel_x;
      item_in.vb[1] = req_data.second_vel_y;
      item_in.vb[2] = req_data.second_vel_z;
      for (int i = 0; i < 3; i++) begin
         d[i] = MAG_BITS'(sp[i]) - MAG_BITS'(fp[i]);
         item_in.neg[i] = d[i][MAG_BITS-1];
         item_in.mag[i] = d[i][MAG_BITS-1] ? MAG_BITS'(-d[i]) : MAG_BITS'(d[i]);
      end
      item_in.zero = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
   end

   assign busy     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push     = start && !busy;
   assign pop      = (count_ff != '0);
   assign count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);

   assign q_out.valid = pop;
   assign q_out.item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sdf_root.sv =====
// Pipelined floor square root of the squared length, one result bit per stage.
`default_nettype none

module sdf_root import sdf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [SQ_BITS-1:0]  in_square,
   input  item_type            in_item,
   output logic                out_valid,
   output logic [LEN_BITS-1:0] out_root,
   output item_type            out_item
);

   logic                valid_ff [ROOT_STEPS];
   logic [RAD_BITS-1:0] rad_ff   [ROOT_STEPS];
   logic [REM_BITS-1:0] rem_ff   [ROOT_STEPS];
   logic [LEN_BITS-1:0] root_ff  [ROOT_STEPS];
   item_type            item_ff  [ROOT_STEPS];

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      logic                prev_valid;
      logic [RAD_BITS-1:0] prev_rad;
      logic [REM_BITS-1:0] prev_rem, rem_sh, trial, rem_in;
      logic [LEN_BITS-1:0] prev_root, root_in;
      item_type            prev_item;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rad   = RAD_BITS'(in_square);
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_item  = in_item;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rad   = rad_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_root  = root_ff[s-1];
         assign prev_item  = item_ff[s-1];
      end

      always_comb begin
         rem_sh = {prev_rem[REM_BITS-3:0], prev_rad[2*(ROOT_STEPS-1-s) +: 2]};
         trial  = {prev_root, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {prev_root[LEN_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {prev_root[LEN_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[s]  <= prev_rad;
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         item_ff[s] <= prev_item;
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS-1];
   assign out_root  = root_ff[ROOT_STEPS-1];
   assign out_item  = item_ff[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/sdf_div.sv =====
// Pipelined restoring divider, three lanes: |d| * 2^30 / length, one quotient bit per stage.
`default_nettype none

module sdf_div import sdf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [LEN_BITS-1:0]       in_len,
   input  item_type                  in_item,
   output logic                      out_valid,
   output logic [LEN_BITS-1:0]       out_len,
   output logic [2:0][QUO_BITS-1:0]  out_quo,
   output item_type                  out_item
);

   logic                     valid_ff [QUO_BITS];
   logic [LEN_BITS-1:0]      len_ff   [QUO_BITS];
   logic [2:0][LEN_BITS-1:0] rem_ff   [QUO_BITS];
   logic [2:0][QUO_BITS-1:0] quo_ff   [QUO_BITS];
   item_type                 item_ff  [QUO_BITS];

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_step
      logic                     prev_valid;
      logic [LEN_BITS-1:0]      prev_len;
      logic [2:0][LEN_BITS-1:0] prev_rem, rem_in;
      logic [2:0][QUO_BITS-1:0] prev_quo, quo_in;
      item_type                 prev_item;
      logic                     nbit;
      logic [DREM_BITS-1:0]     sh, diff;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_len   = in_len;
         assign prev_quo   = '0;
         assign prev_item  = in_item;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign prev_rem[i] = LEN_BITS'(in_item.mag[i] >> 1);
         end
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_len   = len_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_quo   = quo_ff[s-1];
         assign prev_item  = item_ff[s-1];
      end

      always_comb begin
         nbit = 1'b0;
         sh   = '0;
         diff = '0;
         for (int i = 0; i < 3; i++) begin
            if (s == 0) begin
               nbit = prev_item.mag[i][0];
            end else begin
               nbit = 1'b0;
            end
            sh   = {prev_rem[i], nbit};
            diff = sh - {1'b0, prev_len};
            if (sh >= {1'b0, prev_len}) begin
               rem_in[i] = diff[LEN_BITS-1:0];
               quo_in[i] = {prev_quo[i][QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in[i] = sh[LEN_BITS-1:0];
               quo_in[i] = {prev_quo[i][QUO_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         len_ff[s]  <= prev_len;
         rem_ff[s]  <= rem_in;
         quo_ff[s]  <= quo_in;
         item_ff[s] <= prev_item;
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_len   = len_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_item  = item_ff[QUO_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/core/sdf_back.sv =====
// Back end: length, unit direction, damped spring scalars and the two force vectors.
`default_nettype none

module sdf_back import sdf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  slot_type            q_in,
   input  logic [CFG_BITS-1:0] rest,
   input  logic [CFG_BITS-1:0] stiff,
   input  logic [CFG_BITS-1:0] damp,
   output logic                rsp_strobe,
   output rsp_type             rsp_data
);

   // squares and sum
   logic                sq_valid_ff, sum_valid_ff;
   logic [SQ_BITS-1:0]  sq_ff [3];
   logic [SQ_BITS-1:0]  sum_ff;
   item_type            sq_item_ff, sum_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= q_in.valid;
         sum_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SQ_BITS'(q_in.item.mag[i]) * SQ_BITS'(q_in.item.mag[i]);
      end
      sq_item_ff  <= q_in.item;
      sum_ff      <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      sum_item_ff <= sq_item_ff;
   end

   logic                     root_valid;
   logic [LEN_BITS-1:0]      root_len;
   item_type                 root_item;
   logic                     div_valid;
   logic [LEN_BITS-1:0]      div_len;
   logic [2:0][QUO_BITS-1:0] div_quo;
   item_type                 div_item;

   sdf_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid_ff),
      .in_square (sum_ff),
      .in_item   (sum_item_ff),
      .out_valid (root_valid),
      .out_root  (root_len),
      .out_item  (root_item)
   );

   sdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_len    (root_len),
      .in_item   (root_item),
      .out_valid (div_valid),
      .out_len   (div_len),
      .out_quo   (div_quo),
      .out_item  (div_item)
   );

   // stage 0: direction, then seven arithmetic stages
   logic [7:0]          vld_ff;
   word_type            e_line_ff [6][3];
   word_type            va_ff [3];
   word_type            vb_ff [3];
   logic [LEN_BITS-1:0] len_ff;
   prod_type            pa_ff [3];
   prod_type            pb_ff [3];
   word_type            stretch_line_ff [3];
   acc_type             acca_ff, accb_ff;
   word_type            ua_ff, ub_ff;
   prod_type            kss_ff, kdua_ff, kdub_ff;
   word_type            sa_ff, sb_ff;
   prod_type            fa_ff [3];
   prod_type            fb_ff [3];
   word_type            first_ff [3];
   word_type            second_ff [3];
   word_type            e_in [3];
   word_type            qe;

   always_comb begin
      qe = '0;
      for (int i = 0; i < 3; i++) begin
         qe = word_type'({1'b0, div_quo[i]});
         if (div_item.zero) begin
            e_in[i] = '0;
         end else if (div_item.neg[i]) begin
            e_in[i] = -qe;
         end else begin
            e_in[i] = qe;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], div_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         e_line_ff[0][i] <= e_in[i];
         va_ff[i]        <= $signed(div_item.va[i]);
         vb_ff[i]        <= $signed(div_item.vb[i]);
         for (int j = 1; j < 6; j++) begin
            e_line_ff[j][i] <= e_line_ff[j-1][i];
         end
         pa_ff[i] <= prod_type'(e_line_ff[0][i]) * prod_type'(va_ff[i]);
         pb_ff[i] <= prod_type'(e_line_ff[0][i]) * prod_type'(vb_ff[i]);
         fa_ff[i] <= prod_type'(sa_ff) * prod_type'(e_line_ff[5][i]);
         fb_ff[i] <= prod_type'(sb_ff) * prod_type'(e_line_ff[5][i]);
         first_ff[i]  <= sat_word(trunc_shift(wide_type'(fa_ff[i]), UNIT_BITS));
         second_ff[i] <= sat_word(-trunc_shift(wide_type'(fb_ff[i]), UNIT_BITS));
      end
      len_ff <= div_len;
      stretch_line_ff[0] <= sat_word(wide_type'(len_ff) - wide_type'(rest));
      stretch_line_ff[1] <= stretch_line_ff[0];
      stretch_line_ff[2] <= stretch_line_ff[1];
      acca_ff <= ACC_BITS'(wide_type'(pa_ff[0]) + wide_type'(pa_ff[1]) + wide_type'(pa_ff[2]));
      accb_ff <= ACC_BITS'(wide_type'(pb_ff[0]) + wide_type'(pb_ff[1]) + wide_type'(pb_ff[2]));
      ua_ff   <= sat_word(trunc_shift(wide_type'(acca_ff), UNIT_BITS));
      ub_ff   <= sat_word(trunc_shift(wide_type'(accb_ff), UNIT_BITS));
      kss_ff  <= prod_type'({1'b0, stiff}) * prod_type'(stretch_line_ff[2]);
      kdua_ff <= prod_type'({1'b0, damp}) * prod_type'(ua_ff);
      kdub_ff <= prod_type'({1'b0, damp}) * prod_type'(ub_ff);
      sa_ff   <= sat_word(trunc_shift(wide_type'(kss_ff) - wide_type'(kdua_ff), FRACTION_BITS));
      sb_ff   <= sat_word(trunc_shift(wide_type'(kss_ff) - wide_type'(kdub_ff), FRACTION_BITS));
   end

   assign rsp_strobe              = vld_ff[7];
   assign rsp_data.first_force_x  = first_ff[0];
   assign rsp_data.first_force_y  = first_ff[1];
   assign rsp_data.first_force_z  = first_ff[2];
   assign rsp_data.second_force_x = second_ff[0];
   assign rsp_data.second_force_y = second_ff[1];
   assign rsp_data.second_force_z = second_ff[2];

endmodule

`default_nettype wire
